// ===== hdl/mecp_pkg.sv =====
// Shared types, character codes, status codes and lookup functions of the
// markup escape character parser. No dependencies.
package mecp_pkg;

    localparam logic [7:0] CH_BAR       = 8'h7C;
    localparam logic [7:0] CH_BACKTICK  = 8'h60;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_AMP       = 8'h26;

    localparam logic [7:0] LEN_MAX = 8'd155;

    localparam logic [3:0] STAT_PLAIN     = 4'd0;
    localparam logic [3:0] STAT_ESC_START = 4'd1;
    localparam logic [3:0] STAT_DIA_START = 4'd2;
    localparam logic [3:0] STAT_GRP_OPEN  = 4'd3;
    localparam logic [3:0] STAT_QUOTE     = 4'd4;
    localparam logic [3:0] STAT_HELD      = 4'd5;
    localparam logic [3:0] STAT_GRP_CLOSE = 4'd6;
    localparam logic [3:0] STAT_RELEASED  = 4'd7;
    localparam logic [3:0] STAT_DIA_CUE   = 4'd8;
    localparam logic [3:0] STAT_GLYPH     = 4'd9;

    typedef struct packed {
        logic [3:0] status;
        logic [2:0] group_kind;
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic [1:0] char_count;
        logic [7:0] glyph;
        logic       glyph_valid;
        logic [7:0] group_length;
    } result_t;

    function automatic logic [5:0] cue_code(input logic [7:0] c);
        logic [5:0] code;
        code = 6'd0;
        case (c)
            8'h60: code = 6'd2;
            8'h27: code = 6'd3;
            "^":   code = 6'd4;
            8'h22: code = 6'd5;
            "~":   code = 6'd6;
            "=":   code = 6'd7;
            ".":   code = 6'd8;
            "u":   code = 6'd9;
            "v":   code = 6'd10;
            "H":   code = 6'd11;
            "b":   code = 6'd12;
            "c":   code = 6'd13;
            "k":   code = 6'd14;
            "r":   code = 6'd15;
            "R":   code = 6'd16;
            "K":   code = 6'd17;
            "t":   code = 6'd18;
            "/":   code = 6'd19;
            "m":   code = 6'd20;
            "g":   code = 6'd21;
            "G":   code = 6'd22;
            "h":   code = 6'd23;
            "z":   code = 6'd24;
            "e":   code = 6'd25;
            "E":   code = 6'd26;
            "f":   code = 6'd27;
            "F":   code = 6'd28;
            "n":   code = 6'd29;
            "N":   code = 6'd30;
            "C":   code = 6'd31;
            "@":   code = 6'd32;
            ")":   code = 6'd33;
            "%":   code = 6'd34;
            "o":   code = 6'd35;
            "O":   code = 6'd36;
            "$":   code = 6'd37;
            "-":   code = 6'd38;
            "D":   code = 6'd39;
            default: code = 6'd0;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] glyph_lookup(input logic [5:0] code,
                                                input logic [7:0] letter,
                                                input logic [7:0] null_glyph);
        logic [7:0] g;
        g = null_glyph;
        case (code)
            6'd2:
                case (letter)
                    "A": g = 8'd192;  "E": g = 8'd200;  "I": g = 8'd204;
                    "O": g = 8'd210;  "U": g = 8'd217;  "a": g = 8'd224;
                    "e": g = 8'd232;  "i": g = 8'd236;  "o": g = 8'd242;
                    "u": g = 8'd249;
                    default: g = null_glyph;
                endcase
            6'd3:
                case (letter)
                    "A": g = 8'd193;  "C": g = 8'd199;  "E": g = 8'd201;
                    "I": g = 8'd205;  "O": g = 8'd211;  "U": g = 8'd218;
                    "Y": g = 8'd221;  "T": g = 8'd222;  "a": g = 8'd225;
                    "c": g = 8'd231;  "e": g = 8'd233;  "i": g = 8'd237;
                    "o": g = 8'd243;  "u": g = 8'd250;  "y": g = 8'd253;
                    "h": g = 8'd254;
                    default: g = null_glyph;
                endcase
            6'd4:
                case (letter)
                    "A": g = 8'd194;  "E": g = 8'd202;  "I": g = 8'd206;
                    "O": g = 8'd212;  "U": g = 8'd219;  "a": g = 8'd226;
                    "e": g = 8'd234;  "i": g = 8'd238;  "o": g = 8'd244;
                    "u": g = 8'd251;
                    default: g = null_glyph;
                endcase
            6'd5:
                case (letter)
                    "A": g = 8'd196;  "E": g = 8'd208;  "I": g = 8'd207;
                    "O": g = 8'd214;  "U": g = 8'd220;  "a": g = 8'd228;
                    "e": g = 8'd215;  "i": g = 8'd239;  "h": g = 8'd240;
                    "o": g = 8'd246;  "u": g = 8'd252;  "y": g = 8'd255;
                    default: g = null_glyph;
                endcase
            6'd6:
                case (letter)
                    "N": g = 8'd209;  "O": g = 8'd213;  "a": g = 8'd227;
                    "n": g = 8'd241;  "o": g = 8'd245;
                    default: g = null_glyph;
                endcase
            6'd15:
                case (letter)
                    "A": g = 8'd197;  "a": g = 8'd229;
                    default: g = null_glyph;
                endcase
            6'd25:
                case (letter)
                    "A": g = 8'd198;  "a": g = 8'd230;
                    default: g = null_glyph;
                endcase
            6'd19:
                case (letter)
                    "O": g = 8'd216;  "o": g = 8'd248;
                    default: g = null_glyph;
                endcase
            6'd24:
                case (letter)
                    "s": g = 8'd223;
                    default: g = null_glyph;
                endcase
            default: g = null_glyph;
        endcase
        return g;
    endfunction

endpackage

// ===== hdl/mecp_core.sv =====
// Parse state machine and result register of the markup escape parser.
// Depends on mecp_pkg.
module mecp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        char_in,
    input  logic [7:0]        null_glyph,
    output mecp_pkg::result_t result
);

    typedef enum logic [3:0] {
        P_IDLE     = 4'd0,
        P_GRP1     = 4'd1,
        P_GRP2     = 4'd2,
        P_GRP3     = 4'd3,
        P_GRP4     = 4'd4,
        P_GRP5     = 4'd5,
        P_GRP6     = 4'd6,
        P_ESC      = 4'd7,
        P_DIA      = 4'd8,
        P_DIA_HELD = 4'd9
    } parse_state_t;

    parse_state_t      state_reg, state_next;
    logic [7:0]        held_reg, held_next;
    logic [5:0]        code_reg, code_next;
    mecp_pkg::result_t result_reg, result_next;
    logic [7:0]        closer;
    logic [5:0]        cue;

    assign cue = mecp_pkg::cue_code(char_in);

    always_comb
    begin
        case (state_reg)
            P_GRP1:  closer = mecp_pkg::CH_RPAREN;
            P_GRP2:  closer = mecp_pkg::CH_RBRACE;
            P_GRP3:  closer = mecp_pkg::CH_RBRACKET;
            default: closer = mecp_pkg::CH_GT;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        held_next   = held_reg;
        code_next   = code_reg;
        result_next = '0;
        case (state_reg)
            P_GRP1, P_GRP2, P_GRP3, P_GRP4, P_GRP5, P_GRP6:
            begin
                if (char_in == closer)
                begin
                    result_next.status       = mecp_pkg::STAT_GRP_CLOSE;
                    result_next.group_length = held_reg;
                    held_next                = '0;
                    state_next               = P_IDLE;
                end
                else if (state_reg == P_GRP4 && char_in == mecp_pkg::CH_SQUOTE)
                begin
                    result_next.status = mecp_pkg::STAT_QUOTE;
                    state_next         = P_GRP5;
                end
                else if (state_reg == P_GRP4 && char_in == mecp_pkg::CH_DQUOTE)
                begin
                    result_next.status = mecp_pkg::STAT_QUOTE;
                    state_next         = P_GRP6;
                end
                else
                begin
                    result_next.status     = mecp_pkg::STAT_HELD;
                    result_next.group_kind = 3'(state_reg);
                    result_next.first_char = char_in;
                    result_next.char_count = 2'd1;
                    if (held_reg < mecp_pkg::LEN_MAX)
                    begin
                        held_next = held_reg + 8'd1;
                    end
                end
            end
            P_ESC:
            begin
                held_next = '0;
                case (char_in)
                    mecp_pkg::CH_LPAREN:
                    begin
                        result_next.status = mecp_pkg::STAT_GRP_OPEN;
                        state_next         = P_GRP1;
                    end
                    mecp_pkg::CH_LBRACE:
                    begin
                        result_next.status = mecp_pkg::STAT_GRP_OPEN;
                        state_next         = P_GRP2;
                    end
                    mecp_pkg::CH_LBRACKET:
                    begin
                        result_next.status = mecp_pkg::STAT_GRP_OPEN;
                        state_next         = P_GRP3;
                    end
                    mecp_pkg::CH_LT:
                    begin
                        result_next.status = mecp_pkg::STAT_GRP_OPEN;
                        state_next         = P_GRP4;
                    end
                    default:
                    begin
                        held_next               = held_reg;
                        result_next.status      = mecp_pkg::STAT_RELEASED;
                        result_next.first_char  = mecp_pkg::CH_BACKTICK;
                        result_next.second_char = char_in;
                        result_next.char_count  = 2'd2;
                        state_next              = P_IDLE;
                    end
                endcase
            end
            P_DIA:
            begin
                result_next.status = mecp_pkg::STAT_DIA_CUE;
                if (cue != 6'd0)
                begin
                    code_next  = cue;
                    state_next = P_DIA_HELD;
                end
                else if (char_in == mecp_pkg::CH_PLUS || char_in == mecp_pkg::CH_GT ||
                         char_in == mecp_pkg::CH_AMP)
                begin
                    state_next = P_IDLE;
                end
            end
            P_DIA_HELD:
            begin
                result_next.status      = mecp_pkg::STAT_GLYPH;
                result_next.glyph       = mecp_pkg::glyph_lookup(code_reg, char_in,
                                                                 null_glyph);
                result_next.glyph_valid = 1'b1;
                state_next              = P_IDLE;
            end
            default:
            begin
                if (char_in == mecp_pkg::CH_BAR)
                begin
                    result_next.status = mecp_pkg::STAT_DIA_START;
                    state_next         = P_DIA;
                end
                else if (char_in == mecp_pkg::CH_BACKTICK)
                begin
                    result_next.status = mecp_pkg::STAT_ESC_START;
                    state_next         = P_ESC;
                end
                else
                begin
                    result_next.status = mecp_pkg::STAT_PLAIN;
                    state_next         = P_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= P_IDLE;
            held_reg   <= '0;
            code_reg   <= '0;
            result_reg <= '0;
        end
        else if (advance)
        begin
            state_reg  <= state_next;
            held_reg   <= held_next;
            code_reg   <= code_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== hdl/markup_escape_char_parser.sv =====
// Top level of the markup escape character parser: input beat register,
// handshake control and the null glyph register.
// Depends on mecp_pkg and mecp_core.
//
//   channel   | valid         | stall         | payload
//   ----------+---------------+---------------+---------------------------------
//   cue       | cue_valid     | cue_stall     | cue_char
//   result    | result_valid  | result_stall  | status .. group_length (8 ports)
//   config    | null_glyph_wr_en (no stall)   | null_glyph_wr_data
//
// One byte per cycle sustained while result_stall is low; each beat passes the
// input register and then the result register, and its result leaves the
// result register when result_stall is low.
// The parse step between them is one state update plus one table lookup.
// Reset returns the parser to idle with empty registers and null glyph 0.
// A stalled result holds; the input register keeps taking beats until it is
// full behind a held result, then cue_stall rises.
module markup_escape_char_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cue_valid,
    output logic       cue_stall,
    input  logic [7:0] cue_char,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [3:0] status,
    output logic [2:0] group_kind,
    output logic [7:0] first_char,
    output logic [7:0] second_char,
    output logic [1:0] char_count,
    output logic [7:0] glyph,
    output logic       glyph_valid,
    output logic [7:0] group_length,
    input  logic       null_glyph_wr_en,
    input  logic [7:0] null_glyph_wr_data
);

    logic              in_full_reg, in_full_next;
    logic              out_full_reg, out_full_next;
    logic [7:0]        char_reg;
    logic [7:0]        null_glyph_reg;
    logic              accept;
    logic              advance;
    mecp_pkg::result_t result;

    assign advance   = in_full_reg && (!out_full_reg || !result_stall);
    assign cue_stall = in_full_reg && !advance;
    assign accept    = cue_valid && !cue_stall;

    always_comb
    begin
        in_full_next  = accept ? 1'b1 : (advance ? 1'b0 : in_full_reg);
        out_full_next = advance ? 1'b1 :
                        ((out_full_reg && !result_stall) ? 1'b0 : out_full_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            out_full_reg   <= 1'b0;
            char_reg       <= '0;
            null_glyph_reg <= '0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
            if (accept)
            begin
                char_reg <= cue_char;
            end
            if (null_glyph_wr_en)
            begin
                null_glyph_reg <= null_glyph_wr_data;
            end
        end
    end

    mecp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .char_in    (char_reg),
        .null_glyph (null_glyph_reg),
        .result     (result)
    );

    assign result_valid = out_full_reg;
    assign status       = result.status;
    assign group_kind   = result.group_kind;
    assign first_char   = result.first_char;
    assign second_char  = result.second_char;
    assign char_count   = result.char_count;
    assign glyph        = result.glyph;
    assign glyph_valid  = result.glyph_valid;
    assign group_length = result.group_length;

`ifndef ASSERT_OFF
    a_glyph_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (glyph_valid == (status == mecp_pkg::STAT_GLYPH)))
        else $error("glyph_valid disagrees with status");

    a_release_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == mecp_pkg::STAT_RELEASED) |->
        (char_count == 2'd2 && first_char == mecp_pkg::CH_BACKTICK))
        else $error("escape release without backtick pair");

    a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (group_length <= mecp_pkg::LEN_MAX))
        else $error("group length beyond saturation");

    a_advance_fill: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("advanced beat lost before result register");
`endif

endmodule

// ===== tb/sv/markup_escape_char_parser_tb.sv =====
// Self-checking testbench for markup_escape_char_parser: directed and random byte streams
// are checked against a cycle-free parser model kept in this module.
// Depends on mecp_pkg and the markup_escape_char_parser RTL.
module markup_escape_char_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 242;
    localparam logic [38*8-1:0] CUE_CHARS = "`'^\"~=.uvHbckrRKt/mgGhzeEfFnNC@)%oO$-D";

    typedef enum logic [3:0] {
        PS_IDLE     = 4'd0,
        PS_PAREN    = 4'd1,
        PS_BRACE    = 4'd2,
        PS_BRACKET  = 4'd3,
        PS_ANGLE    = 4'd4,
        PS_SQUOTE   = 4'd5,
        PS_DQUOTE   = 4'd6,
        PS_ESC      = 4'd7,
        PS_DIA      = 4'd8,
        PS_DIA_HELD = 4'd9
    } parse_state_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cue_valid = 1'b0;
    logic       cue_stall;
    logic [7:0] cue_char = 8'h00;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [3:0] status;
    logic [2:0] group_kind;
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic [1:0] char_count;
    logic [7:0] glyph;
    logic       glyph_valid;
    logic [7:0] group_length;
    logic       null_glyph_wr_en = 1'b0;
    logic [7:0] null_glyph_wr_data = 8'h00;

    logic [7:0]        text_bytes[$];
    mecp_pkg::result_t predicted_results[$];
    int                mismatches = 0;
    int                sender_idle_pct = 0;
    int                receiver_stall_pct = 0;

    parse_state_t parse_st = PS_IDLE;
    logic [7:0]   held_count = 8'd0;
    logic [5:0]   accent_sel = 6'd0;
    logic [7:0]   null_glyph_now = 8'd0;

    markup_escape_char_parser dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cue_valid          (cue_valid),
        .cue_stall          (cue_stall),
        .cue_char           (cue_char),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .status             (status),
        .group_kind         (group_kind),
        .first_char         (first_char),
        .second_char        (second_char),
        .char_count         (char_count),
        .glyph              (glyph),
        .glyph_valid        (glyph_valid),
        .group_length       (group_length),
        .null_glyph_wr_en   (null_glyph_wr_en),
        .null_glyph_wr_data (null_glyph_wr_data)
    );

    always #10 clk = ~clk;

    function automatic logic [5:0] accent_code(input logic [7:0] c);
        logic [5:0] code;
        code = 6'd0;
        for (int i = 0; i < 38; i++)
            if (CUE_CHARS[(37 - i) * 8 +: 8] == c)
                code = 6'(i + 2);
        return code;
    endfunction

    function automatic logic [7:0] accent_glyph(input logic [5:0] code,
                                                input logic [7:0] letter);
        logic [7:0] g;
        case ({code, letter})
            {6'd2, "A"}: g = 8'd192;   {6'd2, "E"}: g = 8'd200;   {6'd2, "I"}: g = 8'd204;
            {6'd2, "O"}: g = 8'd210;   {6'd2, "U"}: g = 8'd217;   {6'd2, "a"}: g = 8'd224;
            {6'd2, "e"}: g = 8'd232;   {6'd2, "i"}: g = 8'd236;   {6'd2, "o"}: g = 8'd242;
            {6'd2, "u"}: g = 8'd249;
            {6'd3, "A"}: g = 8'd193;   {6'd3, "C"}: g = 8'd199;   {6'd3, "E"}: g = 8'd201;
            {6'd3, "I"}: g = 8'd205;   {6'd3, "O"}: g = 8'd211;   {6'd3, "U"}: g = 8'd218;
            {6'd3, "Y"}: g = 8'd221;   {6'd3, "T"}: g = 8'd222;   {6'd3, "a"}: g = 8'd225;
            {6'd3, "c"}: g = 8'd231;   {6'd3, "e"}: g = 8'd233;   {6'd3, "i"}: g = 8'd237;
            {6'd3, "o"}: g = 8'd243;   {6'd3, "u"}: g = 8'd250;   {6'd3, "y"}: g = 8'd253;
            {6'd3, "h"}: g = 8'd254;
            {6'd4, "A"}: g = 8'd194;   {6'd4, "E"}: g = 8'd202;   {6'd4, "I"}: g = 8'd206;
            {6'd4, "O"}: g = 8'd212;   {6'd4, "U"}: g = 8'd219;   {6'd4, "a"}: g = 8'd226;
            {6'd4, "e"}: g = 8'd234;   {6'd4, "i"}: g = 8'd238;   {6'd4, "o"}: g = 8'd244;
            {6'd4, "u"}: g = 8'd251;
            {6'd5, "A"}: g = 8'd196;   {6'd5, "E"}: g = 8'd208;   {6'd5, "I"}: g = 8'd207;
            {6'd5, "O"}: g = 8'd214;   {6'd5, "U"}: g = 8'd220;   {6'd5, "a"}: g = 8'd228;
            {6'd5, "e"}: g = 8'd215;   {6'd5, "i"}: g = 8'd239;   {6'd5, "h"}: g = 8'd240;
            {6'd5, "o"}: g = 8'd246;   {6'd5, "u"}: g = 8'd252;   {6'd5, "y"}: g = 8'd255;
            {6'd6, "N"}: g = 8'd209;   {6'd6, "O"}: g = 8'd213;   {6'd6, "a"}: g = 8'd227;
            {6'd6, "n"}: g = 8'd241;   {6'd6, "o"}: g = 8'd245;
            {6'd15, "A"}: g = 8'd197;  {6'd15, "a"}: g = 8'd229;
            {6'd25, "A"}: g = 8'd198;  {6'd25, "a"}: g = 8'd230;
            {6'd19, "O"}: g = 8'd216;  {6'd19, "o"}: g = 8'd248;
            {6'd24, "s"}: g = 8'd223;
            default: g = null_glyph_now;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] closer_of(input parse_state_t st);
        case (st)
            PS_PAREN:   return mecp_pkg::CH_RPAREN;
            PS_BRACE:   return mecp_pkg::CH_RBRACE;
            PS_BRACKET: return mecp_pkg::CH_RBRACKET;
            default:    return mecp_pkg::CH_GT;
        endcase
    endfunction

    function automatic mecp_pkg::result_t parse_byte(input logic [7:0] c);
        mecp_pkg::result_t r;
        logic [5:0]        code;
        r = '0;
        case (parse_st)
            PS_PAREN, PS_BRACE, PS_BRACKET, PS_ANGLE, PS_SQUOTE, PS_DQUOTE:
            begin
                if (c == closer_of(parse_st))
                begin
                    r.status       = mecp_pkg::STAT_GRP_CLOSE;
                    r.group_length = held_count;
                    held_count     = 8'd0;
                    parse_st       = PS_IDLE;
                end
                else if (parse_st == PS_ANGLE &&
                         (c == mecp_pkg::CH_SQUOTE || c == mecp_pkg::CH_DQUOTE))
                begin
                    r.status = mecp_pkg::STAT_QUOTE;
                    parse_st = (c == mecp_pkg::CH_SQUOTE) ? PS_SQUOTE : PS_DQUOTE;
                end
                else
                begin
                    r.status     = mecp_pkg::STAT_HELD;
                    r.group_kind = parse_st[2:0];
                    r.first_char = c;
                    r.char_count = 2'd1;
                    if (held_count < mecp_pkg::LEN_MAX)
                        held_count = held_count + 8'd1;
                end
            end
            PS_ESC:
            begin
                held_count = (c == mecp_pkg::CH_LPAREN || c == mecp_pkg::CH_LBRACE ||
                              c == mecp_pkg::CH_LBRACKET || c == mecp_pkg::CH_LT)
                           ? 8'd0 : held_count;
                case (c)
                    mecp_pkg::CH_LPAREN:   parse_st = PS_PAREN;
                    mecp_pkg::CH_LBRACE:   parse_st = PS_BRACE;
                    mecp_pkg::CH_LBRACKET: parse_st = PS_BRACKET;
                    mecp_pkg::CH_LT:       parse_st = PS_ANGLE;
                    default:               parse_st = PS_IDLE;
                endcase
                if (parse_st == PS_IDLE)
                begin
                    r.status      = mecp_pkg::STAT_RELEASED;
                    r.first_char  = mecp_pkg::CH_BACKTICK;
                    r.second_char = c;
                    r.char_count  = 2'd2;
                end
                else
                    r.status = mecp_pkg::STAT_GRP_OPEN;
            end
            PS_DIA:
            begin
                code     = accent_code(c);
                r.status = mecp_pkg::STAT_DIA_CUE;
                if (code != 6'd0)
                begin
                    accent_sel = code;
                    parse_st   = PS_DIA_HELD;
                end
                else if (c == mecp_pkg::CH_PLUS || c == mecp_pkg::CH_GT ||
                         c == mecp_pkg::CH_AMP)
                    parse_st = PS_IDLE;
            end
            PS_DIA_HELD:
            begin
                r.status      = mecp_pkg::STAT_GLYPH;
                r.glyph       = accent_glyph(accent_sel, c);
                r.glyph_valid = 1'b1;
                parse_st      = PS_IDLE;
            end
            default:
            begin
                if (c == mecp_pkg::CH_BAR)
                begin
                    r.status = mecp_pkg::STAT_DIA_START;
                    parse_st = PS_DIA;
                end
                else if (c == mecp_pkg::CH_BACKTICK)
                begin
                    r.status = mecp_pkg::STAT_ESC_START;
                    parse_st = PS_ESC;
                end
                else
                begin
                    r.status = mecp_pkg::STAT_PLAIN;
                    parse_st = PS_IDLE;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_result();
        mecp_pkg::result_t want;
        if (predicted_results.size() == 0)
            report_mismatch("result beat with nothing expected");
        else
        begin
            want = predicted_results.pop_front();
            check_field("status", 8'(status), 8'(want.status));
            check_field("group_kind", 8'(group_kind), 8'(want.group_kind));
            check_field("first_char", first_char, want.first_char);
            check_field("second_char", second_char, want.second_char);
            check_field("char_count", 8'(char_count), 8'(want.char_count));
            check_field("glyph", glyph, want.glyph);
            check_field("glyph_valid", 8'(glyph_valid), 8'(want.glyph_valid));
            check_field("group_length", group_length, want.group_length);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            cue_valid <= 1'b0;
        else
        begin
            if (cue_valid && !cue_stall)
                predicted_results.push_back(parse_byte(cue_char));
            if (!cue_valid || !cue_stall)
            begin
                if (text_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    cue_valid <= 1'b1;
                    cue_char  <= text_bytes.pop_front();
                end
                else
                    cue_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
                check_result();
            result_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cue_valid && !cue_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("markup_escape_char_parser test failed");
        $finish;
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_bytes.push_back(s[i]);
    endtask

    task automatic add_group(input int kind, input int len);
        logic [7:0] opener;
        logic [7:0] closer;
        logic [7:0] b;
        int         q;
        case (kind)
            1:
            begin
                opener = mecp_pkg::CH_LPAREN;
                closer = mecp_pkg::CH_RPAREN;
            end
            2:
            begin
                opener = mecp_pkg::CH_LBRACE;
                closer = mecp_pkg::CH_RBRACE;
            end
            3:
            begin
                opener = mecp_pkg::CH_LBRACKET;
                closer = mecp_pkg::CH_RBRACKET;
            end
            default:
            begin
                opener = mecp_pkg::CH_LT;
                closer = mecp_pkg::CH_GT;
            end
        endcase
        text_bytes.push_back(mecp_pkg::CH_BACKTICK);
        text_bytes.push_back(opener);
        if (opener == mecp_pkg::CH_LT)
        begin
            q = $urandom_range(2);
            if (q == 1)
                text_bytes.push_back(mecp_pkg::CH_SQUOTE);
            else if (q == 2)
                text_bytes.push_back(mecp_pkg::CH_DQUOTE);
        end
        for (int i = 0; i < len; i++)
        begin
            do
                b = 8'($urandom_range(255));
            while (b == closer);
            text_bytes.push_back(b);
        end
        text_bytes.push_back(closer);
    endtask

    task automatic add_diacritic();
        string      favored;
        string      letters;
        logic [7:0] b;
        int         pick;
        favored = "`'^\"~r/ze";
        letters = "AEIOUaeiouYyTChNnsc";
        text_bytes.push_back(mecp_pkg::CH_BAR);
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            case ($urandom_range(2))
                0:       text_bytes.push_back(mecp_pkg::CH_PLUS);
                1:       text_bytes.push_back(mecp_pkg::CH_GT);
                default: text_bytes.push_back(mecp_pkg::CH_AMP);
            endcase
            return;
        end
        if (pick < 25)
        begin
            do
                b = 8'($urandom_range(255));
            while (accent_code(b) != 6'd0 || b == mecp_pkg::CH_PLUS ||
                   b == mecp_pkg::CH_GT || b == mecp_pkg::CH_AMP);
            text_bytes.push_back(b);
            if ($urandom_range(1) == 0)
                return;
        end
        if ($urandom_range(1) == 0)
            text_bytes.push_back(favored[$urandom_range(favored.len() - 1)]);
        else
            text_bytes.push_back(CUE_CHARS[$urandom_range(37) * 8 +: 8]);
        if ($urandom_range(9) < 6)
            text_bytes.push_back(letters[$urandom_range(letters.len() - 1)]);
        else
            text_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic add_phrase();
        logic [7:0] b;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 12)
            text_bytes.push_back(8'($urandom_range(255)));
        else if (pick < 22)
            text_bytes.push_back(8'($urandom_range(8'h7E, 8'h20)));
        else if (pick < 55)
            add_group($urandom_range(4, 1),
                      ($urandom_range(59) == 0) ? $urandom_range(175, 150) : $urandom_range(8));
        else if (pick < 67)
        begin
            do
                b = 8'($urandom_range(255));
            while (b == mecp_pkg::CH_LPAREN || b == mecp_pkg::CH_LBRACE ||
                   b == mecp_pkg::CH_LBRACKET || b == mecp_pkg::CH_LT);
            text_bytes.push_back(mecp_pkg::CH_BACKTICK);
            text_bytes.push_back(b);
        end
        else if (pick < 92)
            add_diacritic();
        else
            text_bytes.push_back(($urandom_range(1) == 0) ? mecp_pkg::CH_BACKTICK
                                                          : mecp_pkg::CH_BAR);
    endtask

    task automatic drain_stream();
        do
            @(negedge clk);
        while (text_bytes.size() != 0 || cue_valid || predicted_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_null_glyph(input logic [7:0] value);
        @(posedge clk);
        null_glyph_wr_en   <= 1'b1;
        null_glyph_wr_data <= value;
        null_glyph_now     <= value;
        @(posedge clk);
        null_glyph_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] cfg;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_null_glyph(8'hA5);
        sender_idle_pct    = 16;
        receiver_stall_pct = 76;
        text_bytes.push_back(8'h00);
        text_bytes.push_back(8'hFF);
        push_text("`(|)`<'\">`7|\"E|?'e|+|~x");

        for (int phase = 0; phase < 6; phase++)
        begin
            drain_stream();
            case (phase)
                0:       cfg = 8'h00;
                1:       cfg = 8'hFF;
                3:       cfg = 8'h01;
                4:       cfg = 8'h80;
                default: cfg = 8'($urandom_range(255));
            endcase
            write_null_glyph(cfg);
            sender_idle_pct    = (phase < 2) ? 16 : (phase < 4) ? 76 : 0;
            receiver_stall_pct = (phase < 2) ? 76 : (phase < 4) ? 16 : 0;
            if (phase == 2 || phase == 5)
                add_group($urandom_range(4, 1), 160);
            while (text_bytes.size() < PHASE_BYTES)
                add_phrase();
        end

        drain_stream();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("markup_escape_char_parser test passed");
        else
            $display("markup_escape_char_parser test failed");
        $finish;
    end

endmodule
